### hdl/umsd_pkg.sv
// Shared types and constants for the unwrapped mean squared displacement block.
// Holds the beat payload structs, register indexes, status codes and a saturating add.
// No dependencies.
package umsd_pkg;

   localparam int COORD_W  = 32;
   localparam int SQ_W     = 64;
   localparam int MSD_W    = 48;
   localparam int CNT_W    = 15;
   localparam int LAG_W    = 8;
   localparam int WIN_W    = 8;
   localparam int BOX_W    = 31;
   localparam int PC_W     = 7;
   localparam int STAT_W   = 2;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int DIV_ITER = 64;
   localparam int CNT_MAX  = 32767;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD   = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] REG_BOX    = 2'd0;
   localparam logic [1:0] REG_WSTART = 2'd1;
   localparam logic [1:0] REG_WEND   = 2'd2;
   localparam logic [1:0] REG_PCOUNT = 2'd3;

   localparam logic [PC_W-1:0]  PC_RESET = 7'd1;
   localparam logic [SQ_W-1:0]  SUM_MAX  = {SQ_W{1'b1}};
   localparam logic [MSD_W-1:0] MSD_MAX  = {MSD_W{1'b1}};

   typedef struct packed {
      logic                      command;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic                      active;
      logic [LAG_W-1:0]          lag;
   } req_type;

   typedef struct packed {
      logic [LAG_W-1:0]  lag_echo;
      logic [MSD_W-1:0]  msd;
      logic [CNT_W-1:0]  sample_count;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic wr_unwrap;
   } lane_ctl_type;

   function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                               input logic [SQ_W-1:0] b);
      logic [SQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SQ_W] ? SUM_MAX : s[SQ_W-1:0];
   endfunction

endpackage

### hdl/umsd_lane.sv
// One axis lane: coordinate store, periodic unwrap on write, and the
// absolute difference and square of two stored entries. Uses umsd_pkg.
module umsd_lane
   import umsd_pkg::*;
#(
   parameter int AW = 14
) (
   input  logic                      clock,
   input  lane_ctl_type              ctl,
   input  logic [AW-1:0]             rd_addr_a,
   input  logic [AW-1:0]             rd_addr_b,
   input  logic [AW-1:0]             wr_addr,
   input  logic signed [COORD_W-1:0] wr_raw,
   input  logic [BOX_W-1:0]          box,
   output logic [SQ_W-1:0]           sq
);

   localparam int DEPTH = 1 << AW;

   logic signed [COORD_W-1:0] mem [DEPTH];
   logic signed [COORD_W-1:0] rd_a_ff, rd_b_ff;
   logic [COORD_W-1:0]        diff_ff;
   logic [SQ_W-1:0]           sq_ff;

   logic signed [COORD_W:0]   dr, adj, d;
   logic signed [COORD_W+1:0] dr2, boxs;
   logic signed [COORD_W:0]   box33, raw33;
   logic signed [COORD_W-1:0] unwrapped, wdata;

   always_comb begin
      raw33 = $signed({wr_raw[COORD_W-1], wr_raw});
      box33 = $signed({2'b00, box});
      dr    = raw33 - $signed({rd_a_ff[COORD_W-1], rd_a_ff});
      dr2   = $signed({dr, 1'b0});
      boxs  = $signed({3'b000, box});
      if (dr2 > boxs) begin
         adj = raw33 - box33;
      end else if (dr2 < -boxs) begin
         adj = raw33 + box33;
      end else begin
         adj = raw33;
      end
      // Saturate to the signed 32-bit range when the sign bits disagree.
      if (adj[COORD_W] != adj[COORD_W-1]) begin
         unwrapped = adj[COORD_W] ? $signed({1'b1, {(COORD_W-1){1'b0}}})
                                  : $signed({1'b0, {(COORD_W-1){1'b1}}});
      end else begin
         unwrapped = adj[COORD_W-1:0];
      end
      wdata = ctl.wr_unwrap ? unwrapped : wr_raw;
      d     = $signed({rd_a_ff[COORD_W-1], rd_a_ff}) - $signed({rd_b_ff[COORD_W-1], rd_b_ff});
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wdata;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      diff_ff <= d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
      sq_ff   <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
   end

   assign sq = sq_ff;

endmodule

### hdl/umsd_merge.sv
// Merge stage: adds the three axis squares with saturation and accumulates
// the running sum and sample count of one query. Uses umsd_pkg.
module umsd_merge
   import umsd_pkg::*;
#(
   parameter int CW = 15
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  logic            in_valid,
   input  logic [SQ_W-1:0] sq_x,
   input  logic [SQ_W-1:0] sq_y,
   input  logic [SQ_W-1:0] sq_z,
   output logic [SQ_W-1:0] sum,
   output logic [CW-1:0]   count,
   output logic            busy
);

   logic            v1_ff, v2_ff;
   logic [SQ_W-1:0] xy_ff, z_ff, d2_ff, sum_ff;
   logic [CW-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      xy_ff <= sat_add(sq_x, sq_y);
      z_ff  <= sq_z;
      d2_ff <= sat_add(xy_ff, z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (v2_ff) begin
         sum_ff   <= sat_add(sum_ff, d2_ff);
         count_ff <= count_ff + CW'(1);
      end
   end

   assign sum   = sum_ff;
   assign count = count_ff;
   assign busy  = v1_ff | v2_ff;

endmodule

### hdl/umsd_div.sv
// Restoring divider, one quotient bit per cycle over a 64-bit dividend.
// Uses umsd_pkg.
module umsd_div
   import umsd_pkg::*;
#(
   parameter int DW = 15
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] dividend,
   input  logic [DW-1:0]   divisor,
   output logic            done,
   output logic [SQ_W-1:0] quotient
);

   localparam int IW = $clog2(DIV_ITER);

   logic            busy_ff, done_ff;
   logic [IW-1:0]   iter_ff;
   logic [SQ_W-1:0] quo_ff;
   logic [DW-1:0]   rem_ff, div_ff;
   logic [DW:0]     trial, diffv;
   logic            ge;

   always_comb begin
      trial = {rem_ff, quo_ff[SQ_W-1]};
      diffv = trial - {1'b0, div_ff};
      ge    = trial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + IW'(1);
            if (iter_ff == IW'(DIV_ITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SQ_W-2:0], ge};
         rem_ff <= ge ? diffv[DW-1:0] : trial[DW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/unwrapped_msd_by_lag.sv
// Load beat: read the previous frame's entry, then unwrap and write.
// Query beat: a rejected lag or window goes straight to the result; otherwise
// the walk feeds one particle pair per cycle through the three axis lanes, and
// the serial divider then forms the mean. One item at a time.
// Reset clears control state and the registers to their reset values; the
// coordinate and active stores are not cleared.
module unwrapped_msd_by_lag
   import umsd_pkg::*;
#(
   parameter int MAX_FRAMES    = 256,
   parameter int MAX_PARTICLES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int AW  = $clog2(MAX_FRAMES * MAX_PARTICLES);
   localparam int LFW = $clog2(MAX_FRAMES + 1);
   localparam int PW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int NW  = $clog2(MAX_PARTICLES + 1);
   localparam int CW  = $clog2(MAX_FRAMES * MAX_PARTICLES + 1);
   localparam int DEPTH = 1 << AW;
   localparam logic [AW-1:0] MP_A = AW'(MAX_PARTICLES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LDW   = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [LFW-1:0]   load_frame_ff, load_frame_in;
   logic [PW-1:0]    load_part_ff, load_part_in;
   logic [WIN_W-1:0] step_ff, step_in;
   logic [PW-1:0]    part_ff, part_in;
   logic [LAG_W-1:0] lag_ff, lag_in;
   logic [2:0]       vld_ff, vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, res_ff, res_in;

   logic [BOX_W-1:0] box_ff;
   logic [WIN_W-1:0] ws_ff, we_ff;
   logic [PC_W-1:0]  pc_ff;

   logic [AW-1:0]             ld_idx_ff;
   logic                      ld_unwrap_ff, ld_act_ff;
   logic signed [COORD_W-1:0] ld_x_ff, ld_y_ff, ld_z_ff;

   logic          act_mem [DEPTH];
   logic          act_q_ff;

   logic [NW-1:0]   eff_cnt;
   logic            req_fire, rsp_fire, bad_lag, out_range, last_part, drained;
   logic [WIN_W:0]  first_step;
   logic [AW-1:0]   ld_idx, ld_prev, walk_a, walk_b, rd_addr_a;
   logic            merge_clear, div_start, div_done;
   logic [SQ_W-1:0] sq_x, sq_y, sq_z, sum, quotient;
   logic [CW-1:0]   count;
   logic            merge_busy;
   lane_ctl_type    lane_ctl;

   // Configuration port.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
         ws_ff  <= '0;
         we_ff  <= '0;
         pc_ff  <= PC_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_BOX:    box_ff <= pwdata[BOX_W-1:0];
            REG_WSTART: ws_ff  <= pwdata[WIN_W-1:0];
            REG_WEND:   we_ff  <= pwdata[WIN_W-1:0];
            REG_PCOUNT: pc_ff  <= pwdata[PC_W-1:0];
            default:    box_ff <= box_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_BOX:    prdata = DATA_W'(box_ff);
         REG_WSTART: prdata = DATA_W'(ws_ff);
         REG_WEND:   prdata = DATA_W'(we_ff);
         REG_PCOUNT: prdata = DATA_W'(pc_ff);
         default:    prdata = '0;
      endcase
   end

   // Clamped particle count and address generation.
   always_comb begin
      if (pc_ff == '0) begin
         eff_cnt = NW'(1);
      end else if (32'(pc_ff) > MAX_PARTICLES) begin
         eff_cnt = NW'(MAX_PARTICLES);
      end else begin
         eff_cnt = NW'(pc_ff);
      end
      ld_idx     = AW'(load_frame_ff) * MP_A + AW'(load_part_ff);
      ld_prev    = ld_idx - MP_A;
      walk_a     = AW'(step_ff) * MP_A + AW'(part_ff);
      walk_b     = AW'(step_ff - lag_ff) * MP_A + AW'(part_ff);
      rd_addr_a  = (state_ff == S_WALK) ? walk_a : ld_prev;
      first_step = {1'b0, ws_ff} + {1'b0, req_data.lag};
      bad_lag    = (req_data.lag == '0) || (first_step > {1'b0, we_ff});
      out_range  = 32'(we_ff) >= 32'(load_frame_ff);
      last_part  = (32'(part_ff) + 32'd1) == 32'(eff_cnt);
      drained    = (vld_ff == '0) && !merge_busy;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   always_comb begin
      state_in      = state_ff;
      load_frame_in = load_frame_ff;
      load_part_in  = load_part_ff;
      step_in       = step_ff;
      part_in       = part_ff;
      lag_in        = lag_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      merge_clear   = 1'b0;
      div_start     = 1'b0;
      lane_ctl      = '0;
      vld_in        = {vld_ff[1], vld_ff[0] & act_q_ff, state_ff == S_WALK};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_LOAD) begin
                  // Loads past the last frame of the store are dropped.
                  if (32'(load_frame_ff) < MAX_FRAMES) begin
                     state_in = S_LDW;
                  end
               end else begin
                  lag_in             = req_data.lag;
                  res_in.lag_echo     = req_data.lag;
                  res_in.msd          = '0;
                  res_in.sample_count = '0;
                  merge_clear         = 1'b1;
                  if (bad_lag) begin
                     res_in.status = ST_BAD;
                     state_in      = S_DONE;
                  end else if (out_range) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     step_in  = first_step[WIN_W-1:0];
                     part_in  = '0;
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_LDW: begin
            lane_ctl.wr_en     = 1'b1;
            lane_ctl.wr_unwrap = ld_unwrap_ff;
            if ((32'(load_part_ff) + 32'd1) >= 32'(eff_cnt)) begin
               load_part_in  = '0;
               load_frame_in = load_frame_ff + LFW'(1);
            end else begin
               load_part_in = load_part_ff + PW'(1);
            end
            state_in = S_IDLE;
         end
         S_WALK: begin
            if (last_part) begin
               part_in = '0;
               if (step_ff == we_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  step_in = step_ff + WIN_W'(1);
               end
            end else begin
               part_in = part_ff + PW'(1);
            end
         end
         S_DRAIN: begin
            if (drained) begin
               res_in.sample_count = (32'(count) > CNT_MAX) ? CNT_W'(CNT_MAX)
                                                            : CNT_W'(count);
               if (count == '0) begin
                  res_in.status = ST_BAD;
                  state_in      = S_DONE;
               end else if (sum == SUM_MAX) begin
                  res_in.status = ST_OK;
                  res_in.msd    = MSD_MAX;
                  state_in      = S_DONE;
               end else begin
                  res_in.status = ST_OK;
                  div_start     = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in.msd = quotient[FRAC_W +: MSD_W];
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // The result register frees up in the same cycle it is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         load_frame_ff <= '0;
         load_part_ff  <= '0;
         step_ff       <= '0;
         part_ff       <= '0;
         lag_ff        <= '0;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_frame_ff <= load_frame_in;
         load_part_ff  <= load_part_in;
         step_ff       <= step_in;
         part_ff       <= part_in;
         lag_ff        <= lag_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= res_ff;
      end
      if (req_fire) begin
         ld_idx_ff    <= ld_idx;
         ld_unwrap_ff <= load_frame_ff != '0;
         ld_x_ff      <= req_data.pos_x;
         ld_y_ff      <= req_data.pos_y;
         ld_z_ff      <= req_data.pos_z;
         ld_act_ff    <= req_data.active;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctl.wr_en) begin
         act_mem[ld_idx_ff] <= ld_act_ff;
      end
      act_q_ff <= act_mem[walk_a];
   end

   umsd_lane #(.AW(AW)) u_lane_x (
      .clock, .ctl(lane_ctl), .rd_addr_a, .rd_addr_b(walk_b), .wr_addr(ld_idx_ff),
      .wr_raw(ld_x_ff), .box(box_ff), .sq(sq_x)
   );

   umsd_lane #(.AW(AW)) u_lane_y (
      .clock, .ctl(lane_ctl), .rd_addr_a, .rd_addr_b(walk_b), .wr_addr(ld_idx_ff),
      .wr_raw(ld_y_ff), .box(box_ff), .sq(sq_y)
   );

   umsd_lane #(.AW(AW)) u_lane_z (
      .clock, .ctl(lane_ctl), .rd_addr_a, .rd_addr_b(walk_b), .wr_addr(ld_idx_ff),
      .wr_raw(ld_z_ff), .box(box_ff), .sq(sq_z)
   );

   umsd_merge #(.CW(CW)) u_merge (
      .clock, .reset, .clear(merge_clear), .in_valid(vld_ff[2]),
      .sq_x, .sq_y, .sq_z, .sum, .count, .busy(merge_busy)
   );

   umsd_div #(.DW(CW)) u_div (
      .clock, .reset, .start(div_start), .dividend(sum), .divisor(count),
      .done(div_done), .quotient
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (vld_ff == '0 && !merge_busy))
      else $error("walk pipeline still busy while idle");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_ok_has_samples: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_OK) |-> (rsp_ff.sample_count != '0))
      else $error("ok status with no samples");

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      32'(load_frame_ff) <= MAX_FRAMES)
      else $error("load frame counter past the store");

endmodule

### sim/unwrapped_msd_by_lag_tb.sv
// Self-checking testbench for unwrapped_msd_by_lag: loads trajectories, queries lags
// and checks every result beat against a cycle-free predictor kept in the bench.
// Depends on umsd_pkg and the unwrapped_msd_by_lag RTL.
module unwrapped_msd_by_lag_tb;
   import umsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAMES     = 256;
   localparam int PARTICLES  = 64;
   localparam int DEPTH      = FRAMES * PARTICLES;
   localparam int CYCLE_CAP  = 3000000;
   localparam int SETTLE     = 40;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   unwrapped_msd_by_lag i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow registers and trajectory store of the predictor.
   logic [BOX_W-1:0]   box_sh = '0;
   logic [WIN_W-1:0]   wstart_sh = '0;
   logic [WIN_W-1:0]   wend_sh = '0;
   logic [PC_W-1:0]    pcount_sh = PC_RESET;
   logic signed [31:0] traj_x [DEPTH];
   logic signed [31:0] traj_y [DEPTH];
   logic signed [31:0] traj_z [DEPTH];
   logic               traj_act [DEPTH];
   int                 loaded_frames = 0;
   int                 load_slot = 0;

   rsp_type msd_expected[$];
   int      idle_pct = 0;
   int      stall_pct = 0;
   logic    hold_on = 1'b0;
   int      errors = 0;
   int      cycles = 0;

   function automatic int eff_particles();
      if (pcount_sh < 1) return 1;
      if (pcount_sh > PARTICLES) return PARTICLES;
      return int'(pcount_sh);
   endfunction

   function automatic logic signed [31:0] sat_coord(input longint v);
      if (v > longint'(S32_MAX)) return S32_MAX;
      if (v < longint'(S32_MIN)) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] unwrap_coord(input logic signed [31:0] raw,
                                                       input logic signed [31:0] prev);
      longint box, dr, r;
      box = longint'({33'd0, box_sh});
      dr  = longint'(raw) - longint'(prev);
      r   = longint'(raw);
      if (2 * dr > box) r = r - box;
      else if (2 * dr < -box) r = r + box;
      return sat_coord(r);
   endfunction

   function automatic logic [63:0] sq_dist(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
      longint     d;
      logic [63:0] m;
      d = longint'(a) - longint'(b);
      m = (d < 0) ? -d : d;
      return m * m;
   endfunction

   function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? SUM_MAX : s[63:0];
   endfunction

   function automatic void record_coord(input req_type beat);
      int idx, pi;
      if (loaded_frames >= FRAMES) return;
      idx = loaded_frames * PARTICLES + load_slot;
      if (loaded_frames > 0) begin
         pi = idx - PARTICLES;
         traj_x[idx] = unwrap_coord(beat.pos_x, traj_x[pi]);
         traj_y[idx] = unwrap_coord(beat.pos_y, traj_y[pi]);
         traj_z[idx] = unwrap_coord(beat.pos_z, traj_z[pi]);
      end else begin
         traj_x[idx] = beat.pos_x;
         traj_y[idx] = beat.pos_y;
         traj_z[idx] = beat.pos_z;
      end
      traj_act[idx] = beat.active;
      load_slot++;
      if (load_slot >= eff_particles()) begin
         load_slot = 0;
         loaded_frames++;
      end
   endfunction

   function automatic rsp_type predict_msd(input logic [LAG_W-1:0] lag);
      rsp_type     r;
      int          n, a, b, count;
      logic [63:0] sum, d2, mean;
      r = '0;
      r.lag_echo = lag;
      n = eff_particles();
      count = 0;
      sum = '0;
      if (lag == 0 || int'(wstart_sh) + int'(lag) > int'(wend_sh)) begin
         r.status = ST_BAD;
      end else if (int'(wend_sh) >= loaded_frames) begin
         r.status = ST_RANGE;
      end else begin
         for (int step = wstart_sh + lag; step <= wend_sh; step++) begin
            for (int i = 0; i < n; i++) begin
               a = step * PARTICLES + i;
               b = (step - lag) * PARTICLES + i;
               if (traj_act[a]) begin
                  d2 = sq_dist(traj_x[a], traj_x[b]);
                  d2 = sum_sat(d2, sq_dist(traj_y[a], traj_y[b]));
                  d2 = sum_sat(d2, sq_dist(traj_z[a], traj_z[b]));
                  sum = sum_sat(sum, d2);
                  count++;
               end
            end
         end
         if (count == 0) begin
            r.status = ST_BAD;
         end else begin
            r.status = ST_OK;
            if (sum == SUM_MAX) mean = {16'd0, MSD_MAX};
            else mean = (sum / 64'(count)) >> FRAC_W;
            r.msd = (mean > {16'd0, MSD_MAX}) ? MSD_MAX : mean[MSD_W-1:0];
            r.sample_count = (count > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(count);
         end
      end
      return r;
   endfunction

   // Receiver: random stalls, plus a long hold-off while hold_on is raised.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("unwrapped_msd_by_lag regression: fail");
         $finish;
      end
      rsp_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (msd_expected.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: lag %0d msd %h", rsp_data.lag_echo,
                        rsp_data.msd);
         end else begin
            rsp_type want;
            want = msd_expected.pop_front();
            if (rsp_data.lag_echo !== want.lag_echo || rsp_data.msd !== want.msd ||
                rsp_data.sample_count !== want.sample_count ||
                rsp_data.status !== want.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected lag %0d msd %h cnt %0d st %0d, got lag %0d msd %h cnt %0d st %0d",
                           want.lag_echo, want.msd, want.sample_count, want.status,
                           rsp_data.lag_echo, rsp_data.msd, rsp_data.sample_count,
                           rsp_data.status);
            end
         end
      end
   end

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (reg_idx)
         REG_BOX:    box_sh    = value[BOX_W-1:0];
         REG_WSTART: wstart_sh = value[WIN_W-1:0];
         REG_WEND:   wend_sh   = value[WIN_W-1:0];
         REG_PCOUNT: pcount_sh = value[PC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      if (beat.command == CMD_QUERY) msd_expected.push_back(predict_msd(beat.lag));
      else record_coord(beat);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (msd_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type load_beat(input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z, input logic act);
      req_type r;
      r = '0;
      r.command = CMD_LOAD;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.active = act;
      r.lag = 8'($urandom);
      return r;
   endfunction

   function automatic req_type query_beat(input logic [LAG_W-1:0] lag);
      req_type r;
      r = '0;
      r.command = CMD_QUERY;
      r.pos_x = $urandom;
      r.pos_y = $urandom;
      r.pos_z = $urandom;
      r.active = 1'($urandom);
      r.lag = lag;
      return r;
   endfunction

   // Mostly a small step from the previous unwrapped position, sometimes with a
   // periodic wrap folded in, sometimes an arbitrary value.
   function automatic logic signed [31:0] next_axis(input logic signed [31:0] prev);
      longint box, span, v;
      box = longint'({33'd0, box_sh});
      span = box / 3 + 2;
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? S32_MAX : S32_MIN;
         default: begin
            v = longint'(prev) + longint'($urandom_range(0, 32'(span))) - span / 2;
            if ($urandom_range(3) == 0) v = $urandom_range(1) ? v + box : v - box;
            return v[31:0];
         end
      endcase
   endfunction

   function automatic req_type random_load();
      int pi;
      logic signed [31:0] px, py, pz;
      px = '0; py = '0; pz = '0;
      if (loaded_frames > 0 && loaded_frames < FRAMES) begin
         pi = (loaded_frames - 1) * PARTICLES + load_slot;
         px = traj_x[pi]; py = traj_y[pi]; pz = traj_z[pi];
      end
      return load_beat(next_axis(px), next_axis(py), next_axis(pz),
                       $urandom_range(7) != 0);
   endfunction

   function automatic req_type random_query();
      int span;
      span = int'(wend_sh) - int'(wstart_sh);
      if (span > 0 && $urandom_range(9) < 8) return query_beat(8'($urandom_range(1, span)));
      return query_beat(8'($urandom));
   endfunction

   // One batch: choose a window, mostly over loaded frames, then a mix of beats.
   task automatic run_batch(input int beats, input int load_pct);
      int s, e;
      if (loaded_frames == 0 || $urandom_range(9) == 0) begin
         s = $urandom_range(255);
         e = $urandom_range(255);
      end else begin
         e = $urandom_range(0, (loaded_frames > 256 ? 256 : loaded_frames) - 1);
         s = e - int'($urandom_range(0, 40));
         if (s < 0) s = 0;
      end
      csr_write(REG_WSTART, s);
      csr_write(REG_WEND, e);
      for (int k = 0; k < beats; k++) begin
         if ($urandom_range(99) < load_pct) send_beat(random_load());
         else send_beat(random_query());
      end
      drain();
   endtask

   task automatic finish_frame();
      while (load_slot != 0) send_beat(random_load());
      drain();
   endtask

   task automatic test_reset_defaults();
      idle_pct = 0; stall_pct = 0;
      send_beat(query_beat(8'd0));
      send_beat(query_beat(8'd1));
      drain();
   endtask

   task automatic test_wide_frames();
      idle_pct = 0; stall_pct = 0;
      csr_write(REG_PCOUNT, 32'd127);
      csr_write(REG_BOX, 32'h7fff_ffff);
      while (loaded_frames < 4) run_batch(60, 85);
      finish_frame();
   endtask

   task automatic test_mid_frames();
      idle_pct = 68; stall_pct = 0;
      csr_write(REG_PCOUNT, 32'd8);
      for (int b = 0; b < 8; b++) begin
         csr_write(REG_BOX, $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(0, 32'h40000)));
         run_batch(50, 45);
      end
      finish_frame();
   endtask

   task automatic test_directed_cases();
      int a;
      idle_pct = 0; stall_pct = 0;
      csr_write(REG_PCOUNT, 32'd2);
      csr_write(REG_BOX, 32'd0);
      a = loaded_frames;
      // Full-scale jumps with no box: the stored values keep their extremes.
      send_beat(load_beat(S32_MIN, S32_MAX, 32'sd0, 1'b1));
      send_beat(load_beat(32'sd0, -32'sd1, 32'sd1, 1'b0));
      send_beat(load_beat(S32_MAX, S32_MIN, S32_MIN, 1'b1));
      send_beat(load_beat(32'sd5, 32'sd5, 32'sd5, 1'b1));
      drain();
      // A box of 2.0: one step just past half a box each way, one saturating.
      csr_write(REG_BOX, 32'h0002_0000);
      send_beat(load_beat(S32_MAX - 32'sh10001, S32_MIN + 32'sh10001, S32_MIN, 1'b1));
      send_beat(load_beat(32'sd5 + 32'sh10001, 32'sd5 - 32'sh10001, 32'sd5, 1'b1));
      // A frame with no active particle.
      send_beat(load_beat(32'sd0, 32'sd0, 32'sd0, 1'b0));
      send_beat(load_beat(32'sd0, 32'sd0, 32'sd0, 1'b0));
      drain();
      csr_write(REG_WSTART, a);
      csr_write(REG_WEND, a + 1);
      send_beat(query_beat(8'd1));
      send_beat(query_beat(8'd0));
      send_beat(query_beat(8'd2));
      send_beat(query_beat(8'd255));
      drain();
      csr_write(REG_WEND, a + 3);
      send_beat(query_beat(8'd1));
      send_beat(query_beat(8'd3));
      drain();
      csr_write(REG_WSTART, a + 2);
      send_beat(query_beat(8'd1));
      drain();
      csr_write(REG_WEND, loaded_frames);
      send_beat(query_beat(8'd1));
      drain();
   endtask

   task automatic test_narrow_frames();
      csr_write(REG_PCOUNT, 32'd0);
      for (int b = 0; loaded_frames < FRAMES; b++) begin
         if (b % 4 == 0) begin
            idle_pct = 0; stall_pct = 68;
         end else if (b % 4 == 1) begin
            idle_pct = 34; stall_pct = 34;
         end else begin
            idle_pct = 0; stall_pct = 0;
         end
         csr_write(REG_BOX, $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(0, 32'h80000)));
         run_batch(60, 55);
      end
   endtask

   task automatic test_backpressure();
      idle_pct = 0; stall_pct = 0;
      fork
         begin
            hold_on <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_on <= 1'b0;
         end
      join_none
      csr_write(REG_WSTART, 32'd10);
      csr_write(REG_WEND, 32'd40);
      for (int k = 0; k < 30; k++) send_beat(random_query());
      drain();
   endtask

   task automatic test_full_store();
      idle_pct = 34; stall_pct = 34;
      csr_write(REG_BOX, 32'h7fff_ffff);
      for (int k = 0; k < 30; k++) send_beat(random_load());
      drain();
      csr_write(REG_WSTART, 32'd0);
      csr_write(REG_WEND, 32'd255);
      send_beat(query_beat(8'd1));
      send_beat(query_beat(8'd255));
      send_beat(query_beat(8'd128));
      drain();
      csr_write(REG_WSTART, 32'd255);
      send_beat(query_beat(8'd1));
      drain();
      for (int b = 0; b < 6; b++) run_batch(40, 20);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_wide_frames();
      test_mid_frames();
      test_directed_cases();
      test_narrow_frames();
      test_backpressure();
      test_full_store();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && msd_expected.size() == 0) begin
         $display("unwrapped_msd_by_lag regression: pass");
      end else begin
         $display("unwrapped_msd_by_lag regression: fail");
      end
      $finish;
   end

endmodule
